/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line follower drive.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/lfpmd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpmd_pkg
// Types, constants and the sensor weighting function of the line follower
// proportional motor drive.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpmd_pkg;

  localparam int unsigned PortWidth  = 8;
  localparam int unsigned GainWidth  = 10;
  localparam int unsigned ShiftWidth = 2;
  localparam int unsigned DutyWidth  = 10;
  localparam int unsigned ErrWidth   = 6;
  localparam int unsigned CalcWidth  = 18;
  localparam int unsigned CfgWidth   = 10;

  localparam logic [GainWidth-1:0]  GainReset  = 10'd100;
  localparam logic [ShiftWidth-1:0] ShiftReset = 2'd0;

  localparam logic signed [CalcWidth-1:0] DutyMax = 18'sd1023;
  localparam logic signed [CalcWidth-1:0] DutyMin = -18'sd1023;

  typedef enum logic {
    CFG_P_GAIN      = 1'b0,
    CFG_POWER_SHIFT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [DutyWidth-1:0] duty;
    logic                 reverse;
  } wheel_t;

  // Port A bit i weighs i-7, port C bit i weighs 7-i.
  function automatic logic signed [ErrWidth-1:0] pattern_error(
    input logic [2*PortWidth-1:0] pat
  );
    int acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (pat[i]) begin
        acc = acc + (i - 7);
      end
      if (pat[8+i]) begin
        acc = acc + (7 - i);
      end
    end
    return ErrWidth'(acc);
  endfunction

endpackage

`default_nettype wire

/* design/lfpmd_in_if.sv */
// ----------------------------------------------------------------------------
// lfpmd_in_if
// Sensor scan channel: two ground-sensor port bytes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpmd_in_if;
  logic                               valid;
  logic                               ready;
  logic [lfpmd_pkg::PortWidth-1:0]    port_a_bits;
  logic [lfpmd_pkg::PortWidth-1:0]    port_c_bits;

  modport source (output valid, output port_a_bits, output port_c_bits, input ready);
  modport sink (input valid, input port_a_bits, input port_c_bits, output ready);
endinterface

`default_nettype wire

/* design/lfpmd_out_if.sv */
// ----------------------------------------------------------------------------
// lfpmd_out_if
// Motor drive result channel: duty, direction and toggle pulses per wheel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpmd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [lfpmd_pkg::DutyWidth-1:0]         left_duty;
  logic [lfpmd_pkg::DutyWidth-1:0]         right_duty;
  logic                                    left_reverse;
  logic                                    right_reverse;
  logic                                    left_pins_toggle;
  logic                                    right_pins_toggle;
  logic signed [lfpmd_pkg::ErrWidth-1:0]   line_error;

  modport source (
    output valid, output left_duty, output right_duty, output left_reverse,
    output right_reverse, output left_pins_toggle, output right_pins_toggle,
    output line_error, input ready
  );
  modport sink (
    input valid, input left_duty, input right_duty, input left_reverse,
    input right_reverse, input left_pins_toggle, input right_pins_toggle,
    input line_error, output ready
  );
endinterface

`default_nettype wire

/* design/lfpmd_mix.sv */
// ----------------------------------------------------------------------------
// lfpmd_mix
// Proportional drive, power shift, spill of excess speed into the other
// wheel and conversion to magnitude and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpmd_mix (
  input  wire logic signed [lfpmd_pkg::ErrWidth-1:0]  err,
  input  wire logic [lfpmd_pkg::GainWidth-1:0]        p_gain,
  input  wire logic [lfpmd_pkg::ShiftWidth-1:0]       power_shift,
  output lfpmd_pkg::wheel_t                           left,
  output lfpmd_pkg::wheel_t                           right
);

  logic signed [lfpmd_pkg::GainWidth+lfpmd_pkg::ErrWidth:0] drive;
  logic signed [lfpmd_pkg::CalcWidth-1:0] drive_ext;
  logic signed [lfpmd_pkg::CalcWidth-1:0] left_raw;
  logic signed [lfpmd_pkg::CalcWidth-1:0] right_raw;
  logic signed [lfpmd_pkg::CalcWidth-1:0] left_sh;
  logic signed [lfpmd_pkg::CalcWidth-1:0] right_sh;
  logic signed [lfpmd_pkg::CalcWidth-1:0] left_sp;
  logic signed [lfpmd_pkg::CalcWidth-1:0] right_sp;
  logic signed [lfpmd_pkg::CalcWidth-1:0] left_mag;
  logic signed [lfpmd_pkg::CalcWidth-1:0] right_mag;
  logic [1:0] shift_eff;

  always_comb begin
    drive     = $signed({1'b0, p_gain}) * err;
    drive_ext = lfpmd_pkg::CalcWidth'(drive);
    left_raw  = lfpmd_pkg::DutyMax + drive_ext;
    right_raw = lfpmd_pkg::DutyMax - drive_ext;
    shift_eff = power_shift[1] ? 2'd2 : {1'b0, power_shift[0]};
    left_sh   = left_raw >>> shift_eff;
    right_sh  = right_raw >>> shift_eff;

    left_sp  = left_sh;
    right_sp = right_sh;
    if (left_sh > lfpmd_pkg::DutyMax) begin
      right_sp = right_sh - (left_sh - lfpmd_pkg::DutyMax);
      left_sp  = lfpmd_pkg::DutyMax;
      if (right_sp < lfpmd_pkg::DutyMin) begin
        right_sp = lfpmd_pkg::DutyMin;
      end
    end else if (right_sh > lfpmd_pkg::DutyMax) begin
      left_sp  = left_sh - (right_sh - lfpmd_pkg::DutyMax);
      right_sp = lfpmd_pkg::DutyMax;
      if (left_sp < lfpmd_pkg::DutyMin) begin
        left_sp = lfpmd_pkg::DutyMin;
      end
    end

    left.reverse  = left_sp[lfpmd_pkg::CalcWidth-1];
    right.reverse = right_sp[lfpmd_pkg::CalcWidth-1];
    left_mag      = left.reverse ? -left_sp : left_sp;
    right_mag     = right.reverse ? -right_sp : right_sp;
    left.duty     = left_mag[lfpmd_pkg::DutyWidth-1:0];
    right.duty    = right_mag[lfpmd_pkg::DutyWidth-1:0];
  end

endmodule

`default_nettype wire

/* design/line_follow_p_motor_drive.sv */
// ----------------------------------------------------------------------------
// line_follow_p_motor_drive
// Line follower proportional motor drive: sensor scans in, wheel duty and
// direction out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   in_ch    sink       port_a_bits, port_c_bits (one sensor scan)
//   out_ch   source     duties, reverse flags, pin toggles, line_error
//   cfg_*    write      p_gain (index 0), power_shift (index 1)
//
// Each transaction passes through the scan register, where the held
// pattern is updated and the line error is formed, and through the
// multiply and mix logic on its way into the result register.
// A transaction is taken in every cycle while out_ch is not stalled.
// A stalled result register stalls the scan register and then in_ch.
// Reset clears the held pattern, both directions and the pipeline valids,
// and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module line_follow_p_motor_drive (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lfpmd_in_if.sink                                in_ch,
  lfpmd_out_if.source                             out_ch,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [lfpmd_pkg::CfgWidth-1:0]     cfg_wdata
);

  logic [lfpmd_pkg::GainWidth-1:0]   p_gain_r;
  logic [lfpmd_pkg::ShiftWidth-1:0]  power_shift_r;
  logic [2*lfpmd_pkg::PortWidth-1:0] held_r;
  logic [2*lfpmd_pkg::PortWidth-1:0] held_nxt;
  logic                              s1_v_r;
  logic signed [lfpmd_pkg::ErrWidth-1:0] s1_err_r;
  logic                              out_v_r;
  logic                              left_dir_r;
  logic                              right_dir_r;
  logic [lfpmd_pkg::DutyWidth-1:0]   out_left_duty_r;
  logic [lfpmd_pkg::DutyWidth-1:0]   out_right_duty_r;
  logic                              out_left_rev_r;
  logic                              out_right_rev_r;
  logic                              out_left_tog_r;
  logic                              out_right_tog_r;
  logic signed [lfpmd_pkg::ErrWidth-1:0] out_err_r;
  logic                              in_take;
  logic                              out_load;
  logic                              out_free;
  lfpmd_pkg::wheel_t                 left_w;
  lfpmd_pkg::wheel_t                 right_w;

  assign out_free  = !out_v_r || out_ch.ready;
  assign out_load  = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_take   = in_ch.valid && in_ch.ready;
  assign held_nxt  = ((in_ch.port_a_bits | in_ch.port_c_bits) != '0)
                   ? {in_ch.port_c_bits, in_ch.port_a_bits} : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r      <= lfpmd_pkg::GainReset;
      power_shift_r <= lfpmd_pkg::ShiftReset;
    end else if (cfg_we) begin
      unique case (lfpmd_pkg::cfg_index_t'(cfg_index))
        lfpmd_pkg::CFG_P_GAIN:      p_gain_r <= cfg_wdata[lfpmd_pkg::GainWidth-1:0];
        lfpmd_pkg::CFG_POWER_SHIFT: power_shift_r <= cfg_wdata[lfpmd_pkg::ShiftWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        held_r <= held_nxt;
      end
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_err_r <= lfpmd_pkg::pattern_error(held_nxt);
    end
  end

  lfpmd_mix u_mix (
    .err         (s1_err_r),
    .p_gain      (p_gain_r),
    .power_shift (power_shift_r),
    .left        (left_w),
    .right       (right_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      left_dir_r  <= 1'b0;
      right_dir_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      if (out_load) begin
        left_dir_r  <= left_w.reverse;
        right_dir_r <= right_w.reverse;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_duty_r  <= left_w.duty;
      out_right_duty_r <= right_w.duty;
      out_left_rev_r   <= left_w.reverse;
      out_right_rev_r  <= right_w.reverse;
      out_left_tog_r   <= left_w.reverse ^ left_dir_r;
      out_right_tog_r  <= right_w.reverse ^ right_dir_r;
      out_err_r        <= s1_err_r;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.left_duty         = out_left_duty_r;
  assign out_ch.right_duty        = out_right_duty_r;
  assign out_ch.left_reverse      = out_left_rev_r;
  assign out_ch.right_reverse     = out_right_rev_r;
  assign out_ch.left_pins_toggle  = out_left_tog_r;
  assign out_ch.right_pins_toggle = out_right_tog_r;
  assign out_ch.line_error        = out_err_r;

  `ASSERT_SAME(a_left_dir_matches, clk, rst_n, out_v_r, out_left_rev_r == left_dir_r)
  `ASSERT_SAME(a_right_dir_matches, clk, rst_n, out_v_r, out_right_rev_r == right_dir_r)
  `ASSERT_NEXT(a_scan_moves_on, clk, rst_n, s1_v_r && !out_v_r, out_v_r)
  `ASSERT_NEXT(a_held_update, clk, rst_n, in_take && (in_ch.port_a_bits != '0), held_r[7:0] == $past(in_ch.port_a_bits))

endmodule

`default_nettype wire
